[rtl/poi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pkg: shared types and constants of the planar odometry integrator
// fixed-point widths, cordic constants, arctangent table, controller codes
// and the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package poi_pkg;

    // widths
    localparam int ANG_W      = 24;  // cordic angle, q.20 radians
    localparam int CXY_W      = 34;  // cordic x and y, q1.30 with headroom
    localparam int MUL_A_W    = 32;  // multiplier operand a
    localparam int MUL_B_W    = 17;  // multiplier operand b
    localparam int PROD_W     = 49;  // multiplier product
    localparam int DH_W       = 18;  // rounded heading increment
    localparam int HSUM_W     = 19;  // heading sum before wrap
    localparam int ATAN_IDX_W = 5;

    // cordic constants
    localparam logic signed [CXY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] PI_Q20          = 24'sd3294199;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q20     = 24'sd1647099;

    // heading wrap constants, q3.13
    localparam logic signed [HSUM_W-1:0] HEAD_PI      = 19'sd25736;
    localparam logic signed [HSUM_W-1:0] HEAD_TWO_PI  = 19'sd51472;
    localparam logic signed [HSUM_W-1:0] HEAD_FOUR_PI = 19'sd102944;

    // atan(2^-i) in q.20 radians
    function automatic logic [19:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
        logic [19:0] v;
        case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // multiply sequence, one operation per cycle
    typedef enum logic [2:0] {
        OP_VF_C  = 3'd0,  // vf * cos
        OP_VL_S  = 3'd1,  // vl * sin
        OP_VF_S  = 3'd2,  // vf * sin
        OP_VL_C  = 3'd3,  // vl * cos
        OP_AX_DT = 3'd4,  // (vf*cos - vl*sin) * dt
        OP_BY_DT = 3'd5,  // (vf*sin + vl*cos) * dt
        OP_WR_DT = 3'd6,  // yaw rate * dt
        OP_HEAD  = 3'd7   // heading update, no product
    } mul_op_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_HSTART = 7'b0000010,
        S_HWAIT  = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_QSTART = 7'b0010000,
        S_QWAIT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clear_pose;
        logic    cordic_start;
        logic    ang_half;
        logic    latch_sc;
        logic    mul_en;
        mul_op_t op;
        logic    out_load;
    } poi_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_free;
    } poi_sts_t;

endpackage

[rtl/poi_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_cordic: iterative rotation-mode sine and cosine
// one micro-rotation per cycle, quadrant folding at start, q1.14 results
// ----------------------------------------------------------------------------
module poi_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [poi_pkg::ANG_W-1:0]  angle,
    output logic                              done,
    output logic signed [15:0]                cos_q14,
    output logic signed [15:0]                sin_q14
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic signed [poi_pkg::CXY_W-1:0] x_reg, x_next;
    logic signed [poi_pkg::CXY_W-1:0] y_reg, y_next;
    logic signed [poi_pkg::ANG_W-1:0] z_reg, z_next;
    logic                             neg_reg, neg_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [STEP_W-1:0]                step_reg, step_next;

    logic signed [poi_pkg::CXY_W-1:0] xs, ys, x_fin, y_fin;
    logic signed [poi_pkg::ANG_W-1:0] at, z_init;
    logic                             neg_init, last;

    function automatic logic signed [15:0] to_q14(input logic signed [poi_pkg::CXY_W-1:0] v);
        logic signed [poi_pkg::CXY_W-1:0] r;
        logic signed [15:0]               q;
        r = (v + 34'sd32768) >>> 16;
        if (r > 34'sd16384) begin
            q = 16'sd16384;
        end else if (r < -34'sd16384) begin
            q = -16'sd16384;
        end else begin
            q = 16'(r);
        end
        return q;
    endfunction

    // fold angles beyond a quarter turn, results negated at the end
    always_comb
    begin
        if (angle > poi_pkg::HALF_PI_Q20) begin
            z_init   = angle - poi_pkg::PI_Q20;
            neg_init = 1'b1;
        end else if (angle < -poi_pkg::HALF_PI_Q20) begin
            z_init   = angle + poi_pkg::PI_Q20;
            neg_init = 1'b1;
        end else begin
            z_init   = angle;
            neg_init = 1'b0;
        end
    end

    assign xs   = x_reg >>> step_reg;
    assign ys   = y_reg >>> step_reg;
    assign at   = poi_pkg::ANG_W'({1'b0, poi_pkg::atan_q20(poi_pkg::ATAN_IDX_W'(step_reg))});
    assign last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = poi_pkg::CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = z_init;
            neg_next  = neg_init;
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            if (!z_reg[poi_pkg::ANG_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign x_fin   = neg_reg ? -x_reg : x_reg;
    assign y_fin   = neg_reg ? -y_reg : y_reg;
    assign cos_q14 = to_q14(x_fin);
    assign sin_q14 = to_q14(y_fin);
    assign done    = done_reg;

endmodule

[rtl/poi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_datapath: pose state, shared multiplier, cordic and result register
// executes the commands of the controller one step per cycle
// ----------------------------------------------------------------------------
module poi_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  poi_pkg::poi_cmd_t  cmd,
    output poi_pkg::poi_sts_t  sts,
    input  logic signed [15:0] vel_forward,
    input  logic signed [15:0] vel_lateral,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        elapsed_time,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] position_x,
    output logic signed [31:0] position_y,
    output logic signed [15:0] heading,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic [31:0]        tick_number
);

    // latched item
    logic signed [15:0] vf_reg, vl_reg, wr_reg;
    logic [15:0]        dt_reg;

    // pose state
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [15:0] head_reg, head_next;
    logic [31:0]        tick_reg, tick_next;

    // working registers
    logic signed [15:0]                c_reg, s_reg;
    logic signed [poi_pkg::PROD_W-1:0] prod_reg;
    logic signed [31:0]                acc_a_reg, acc_a_next;
    logic signed [31:0]                acc_b_reg, acc_b_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] o_x_reg, o_y_reg;
    logic signed [15:0] o_head_reg, o_qz_reg, o_qw_reg;
    logic [31:0]        o_tick_reg;

    logic signed [poi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [poi_pkg::MUL_B_W-1:0] mul_b, dt_s;
    logic signed [poi_pkg::PROD_W-1:0]  mul_p, rnd_pos, rnd_head;
    logic signed [31:0]                 dpos;
    logic signed [poi_pkg::DH_W-1:0]    dhead;
    logic signed [poi_pkg::HSUM_W-1:0]  hsum, hwrap;
    logic signed [poi_pkg::ANG_W-1:0]   ang_full, ang_half, angle;
    logic signed [15:0]                 cor_cos, cor_sin;
    logic                               cor_done;

    // cordic angle: heading * 128 for the rotation, * 64 for the half angle
    assign ang_full = {head_reg[15], head_reg, 7'b0};
    assign ang_half = {{2{head_reg[15]}}, head_reg, 6'b0};
    assign angle    = cmd.ang_half ? ang_half : ang_full;

    poi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (angle),
        .done    (cor_done),
        .cos_q14 (cor_cos),
        .sin_q14 (cor_sin)
    );

    // shared multiplier operands
    assign dt_s = {1'b0, dt_reg};

    always_comb
    begin
        case (cmd.op)
            poi_pkg::OP_VF_C:  begin mul_a = 32'(vf_reg); mul_b = 17'(c_reg); end
            poi_pkg::OP_VL_S:  begin mul_a = 32'(vl_reg); mul_b = 17'(s_reg); end
            poi_pkg::OP_VF_S:  begin mul_a = 32'(vf_reg); mul_b = 17'(s_reg); end
            poi_pkg::OP_VL_C:  begin mul_a = 32'(vl_reg); mul_b = 17'(c_reg); end
            poi_pkg::OP_AX_DT: begin mul_a = acc_a_reg;   mul_b = dt_s;       end
            poi_pkg::OP_BY_DT: begin mul_a = acc_b_reg;   mul_b = dt_s;       end
            poi_pkg::OP_WR_DT: begin mul_a = 32'(wr_reg); mul_b = dt_s;       end
            default:           begin mul_a = '0;          mul_b = '0;         end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half up from q.38 to q16.16, and from q.28 to q3.13
    assign rnd_pos  = prod_reg + 49'sd2097152;
    assign dpos     = 32'(rnd_pos >>> 22);
    assign rnd_head = prod_reg + 49'sd16384;
    assign dhead    = poi_pkg::DH_W'(rnd_head >>> 15);

    // heading wrap into [-pi, pi), at most two turns either way
    assign hsum = poi_pkg::HSUM_W'(head_reg) + poi_pkg::HSUM_W'(dhead) + poi_pkg::HEAD_PI;

    always_comb
    begin
        if (hsum >= poi_pkg::HEAD_FOUR_PI) begin
            hwrap = hsum - poi_pkg::HEAD_FOUR_PI;
        end else if (hsum >= poi_pkg::HEAD_TWO_PI) begin
            hwrap = hsum - poi_pkg::HEAD_TWO_PI;
        end else if (!hsum[poi_pkg::HSUM_W-1]) begin
            hwrap = hsum;
        end else if (hsum >= -poi_pkg::HEAD_TWO_PI) begin
            hwrap = hsum + poi_pkg::HEAD_TWO_PI;
        end else begin
            hwrap = hsum + poi_pkg::HEAD_FOUR_PI;
        end
    end

    // state updates; every op but the first consumes the prior op's product
    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        head_next  = head_reg;
        tick_next  = tick_reg;
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        if (cmd.clear_pose) begin
            pos_x_next = '0;
            pos_y_next = '0;
            head_next  = '0;
        end else if (cmd.mul_en) begin
            case (cmd.op)
                poi_pkg::OP_VL_S:  acc_a_next = prod_reg[31:0];
                poi_pkg::OP_VF_S:  acc_a_next = acc_a_reg - prod_reg[31:0];
                poi_pkg::OP_VL_C:  acc_b_next = prod_reg[31:0];
                poi_pkg::OP_AX_DT: acc_b_next = acc_b_reg + prod_reg[31:0];
                poi_pkg::OP_BY_DT: pos_x_next = pos_x_reg + dpos;
                poi_pkg::OP_WR_DT: pos_y_next = pos_y_reg + dpos;
                poi_pkg::OP_HEAD:
                begin
                    head_next = 16'(hwrap - poi_pkg::HEAD_PI);
                    tick_next = tick_reg + 32'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            head_reg  <= '0;
            tick_reg  <= '0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            head_reg  <= head_next;
            tick_reg  <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            vf_reg <= vel_forward;
            vl_reg <= vel_lateral;
            wr_reg <= yaw_rate;
            dt_reg <= elapsed_time;
        end
        if (cmd.latch_sc) begin
            c_reg <= cor_cos;
            s_reg <= cor_sin;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
    end

    // result register, free once empty or taken
    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign sts.cordic_done = cor_done;

    always_comb
    begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            o_x_reg    <= pos_x_reg;
            o_y_reg    <= pos_y_reg;
            o_head_reg <= head_reg;
            o_qz_reg   <= cor_sin;
            o_qw_reg   <= cor_cos;
            o_tick_reg <= tick_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position_x  = o_x_reg;
    assign position_y  = o_y_reg;
    assign heading     = o_head_reg;
    assign quat_z      = o_qz_reg;
    assign quat_w      = o_qw_reg;
    assign tick_number = o_tick_reg;

endmodule

[rtl/poi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_ctrl: sequencing state machine of the odometry integrator
// walks ticks through cordic and multiplies, fixes via quaternion and result
// ----------------------------------------------------------------------------
module poi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    output logic              in_stall,
    output poi_pkg::poi_cmd_t cmd,
    input  poi_pkg::poi_sts_t sts
);

    poi_pkg::state_t  state_reg, state_next;
    poi_pkg::mul_op_t op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            poi_pkg::S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load       = 1'b1;
                    cmd.clear_pose = command;
                    state_next     = command ? poi_pkg::S_QSTART : poi_pkg::S_HSTART;
                end
            end
            poi_pkg::S_HSTART:
            begin
                cmd.cordic_start = 1'b1;
                state_next       = poi_pkg::S_HWAIT;
            end
            poi_pkg::S_HWAIT:
            begin
                if (sts.cordic_done) begin
                    cmd.latch_sc = 1'b1;
                    op_next      = poi_pkg::OP_VF_C;
                    state_next   = poi_pkg::S_MUL;
                end
            end
            poi_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                op_next    = poi_pkg::mul_op_t'(op_reg + 3'd1);
                if (op_reg == poi_pkg::OP_HEAD) begin
                    state_next = poi_pkg::S_QSTART;
                end
            end
            poi_pkg::S_QSTART:
            begin
                cmd.cordic_start = 1'b1;
                cmd.ang_half     = 1'b1;
                state_next       = poi_pkg::S_QWAIT;
            end
            poi_pkg::S_QWAIT:
            begin
                if (sts.cordic_done) begin
                    state_next = poi_pkg::S_OUT;
                end
            end
            poi_pkg::S_OUT:
            begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = poi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = poi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= poi_pkg::S_IDLE;
            op_reg    <= poi_pkg::OP_VF_C;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_stall = (state_reg != poi_pkg::S_IDLE);

endmodule

[rtl/planar_odometry_integrator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_top: dead-reckoning pose integrator
// rotates body-frame velocity by the heading, integrates position and
// heading, and reports pose, planar quaternion and tick count per item
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | into      | in_valid/in_stall  | command, vel_forward, vel_lateral,
//          |           |                    | yaw_rate, elapsed_time
//  out     | out of    | out_valid/out_stall| position_x, position_y, heading,
//          |           |                    | quat_z, quat_w, tick_number
//
//  an integrate item runs two passes of the iterative cordic, one
//  micro-rotation per cycle, plus eight steps on the single shared
//  multiplier; a reset item clears the pose and runs one cordic pass
//  one item at a time; in_stall is high from the transfer until the result
//  sits in the output register, so the next item is taken while it waits
//  out_stall holds the result register; the controller then waits before
//  loading the next result
//  rst_n clears the pose, the tick count and all control state
//
module planar_odometry_integrator_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [15:0] vel_forward,
    input  logic signed [15:0] vel_lateral,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        elapsed_time,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] position_x,
    output logic signed [31:0] position_y,
    output logic signed [15:0] heading,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic [31:0]        tick_number
);

    poi_pkg::poi_cmd_t cmd;
    poi_pkg::poi_sts_t sts;

    // sequencer: one state per phase of the item
    poi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // pose state, cordic, shared multiplier and the result register
    poi_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .vel_forward  (vel_forward),
        .vel_lateral  (vel_lateral),
        .yaw_rate     (yaw_rate),
        .elapsed_time (elapsed_time),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .position_x   (position_x),
        .position_y   (position_y),
        .heading      (heading),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .tick_number  (tick_number)
    );

endmodule

[rtl/poi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_checker: port-level checks of the odometry integrator
// output handshake, result ranges and one-at-a-time input behavior
// ----------------------------------------------------------------------------
module poi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] position_x,
    input logic signed [31:0] position_y,
    input logic signed [15:0] heading,
    input logic signed [15:0] quat_z,
    input logic signed [15:0] quat_w,
    input logic [31:0]        tick_number
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(position_x) && $stable(position_y)
            && $stable(heading) && $stable(quat_z) && $stable(quat_w)
            && $stable(tick_number))
        else $error("result changed under stall");

    // heading stays wrapped into [-pi, pi)
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading >= -16'sd25736 && heading <= 16'sd25735)
        else $error("heading out of range");

    // quaternion clamped to unit range
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_z >= -16'sd16384 && quat_z <= 16'sd16384
            && quat_w >= -16'sd16384 && quat_w <= 16'sd16384)
        else $error("quaternion out of range");

    // after a transfer the block is busy with that item
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken back to back");

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (.*);

[bench/odometry_pose_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_pose_checker: pose prediction and result comparison
// watches both channels of the odometry integrator, keeps its own pose
// state, predicts the result of every transfer in and compares every
// result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module odometry_pose_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               command,
    input  logic signed [15:0] vel_forward,
    input  logic signed [15:0] vel_lateral,
    input  logic signed [15:0] yaw_rate,
    input  logic [15:0]        elapsed_time,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] position_x,
    input  logic signed [31:0] position_y,
    input  logic signed [15:0] heading,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic [31:0]        tick_number,
    output int                 fail_count,
    output int                 pending_count
);

    localparam longint ROT_GAIN_Q30   = 652032874;
    localparam longint ROT_PI_Q20     = 3294199;
    localparam longint ROT_HALF_PI_Q20 = 1647099;
    localparam longint HEAD_HALF_TURN = 25736;
    localparam longint HEAD_TURN      = 51472;
    localparam int     ARCTAN_LEN     = 24;
    localparam int     SHOWN_LIMIT    = 10;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] head;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic [31:0]        ticks;
    } pose_t;

    logic [31:0] acc_x;
    logic [31:0] acc_y;
    longint      acc_head;
    logic [31:0] acc_ticks;
    pose_t       expected_poses[$];
    pose_t       want;
    pose_t       got;

    function automatic longint arctan_q20(input int i);
        case (i)
            0:       return 823550;
            1:       return 486170;
            2:       return 256879;
            3:       return 130396;
            4:       return 65451;
            5:       return 32757;
            6:       return 16383;
            7:       return 8192;
            8:       return 4096;
            9:       return 2048;
            10:      return 1024;
            11:      return 512;
            12:      return 256;
            13:      return 128;
            14:      return 64;
            15:      return 32;
            16:      return 16;
            17:      return 8;
            18:      return 4;
            19:      return 2;
            20:      return 1;
            default: return 0;
        endcase
    endfunction

    // round half up, then drop s fraction bits
    function automatic longint round_drop(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] to_unit_q14(input longint v);
        longint r;
        r = round_drop(v, 16);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    // angle in q.20 radians, cosine and sine in q1.14
    function automatic void cordic_sincos(input longint ang,
                                          output logic signed [15:0] c,
                                          output logic signed [15:0] s);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        int     i;
        x    = ROT_GAIN_Q30;
        y    = 0;
        z    = ang;
        flip = 1'b0;
        if (z > ROT_HALF_PI_Q20) begin
            z    = z - ROT_PI_Q20;
            flip = 1'b1;
        end
        else if (z < -ROT_HALF_PI_Q20) begin
            z    = z + ROT_PI_Q20;
            flip = 1'b1;
        end
        for (i = 0; i < CORDIC_STEPS && i < ARCTAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q20(i);
            end
            else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q20(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = to_unit_q14(x);
        s = to_unit_q14(y);
    endfunction

    // one tick of dead reckoning, or a pose clear on a fix
    task automatic advance_pose(input logic cmd,
                                input logic signed [15:0] vf,
                                input logic signed [15:0] vl,
                                input logic signed [15:0] wr,
                                input logic [15:0] dt,
                                output pose_t p);
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        longint fwd;
        longint lat;
        longint rate;
        longint span;
        longint dx;
        longint dy;
        longint h;
        if (cmd) begin
            acc_x    = '0;
            acc_y    = '0;
            acc_head = 0;
        end
        else begin
            fwd  = vf;
            lat  = vl;
            rate = wr;
            span = dt;
            // rotation uses the heading from before this tick
            cordic_sincos(acc_head * 128, c, s);
            dx = round_drop((fwd * c - lat * s) * span, 22);
            dy = round_drop((fwd * s + lat * c) * span, 22);
            acc_x = acc_x + dx[31:0];
            acc_y = acc_y + dy[31:0];
            h = acc_head + round_drop(rate * span, 15) + HEAD_HALF_TURN;
            h = h % HEAD_TURN;
            if (h < 0)
                h = h + HEAD_TURN;
            acc_head  = h - HEAD_HALF_TURN;
            acc_ticks = acc_ticks + 1;
        end
        cordic_sincos(acc_head * 64, qw, qz);
        p.px    = acc_x;
        p.py    = acc_y;
        p.head  = acc_head[15:0];
        p.qz    = qz;
        p.qw    = qw;
        p.ticks = acc_ticks;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            acc_x     = '0;
            acc_y     = '0;
            acc_head  = 0;
            acc_ticks = '0;
            expected_poses.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                got.px    = position_x;
                got.py    = position_y;
                got.head  = heading;
                got.qz    = quat_z;
                got.qw    = quat_w;
                got.ticks = tick_number;
                if (expected_poses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_LIMIT)
                        $display("%0t unexpected result: x=%0d y=%0d h=%0d qz=%0d qw=%0d n=%0d",
                                 $time, got.px, got.py, got.head, got.qz, got.qw,
                                 got.ticks);
                end
                else begin
                    want = expected_poses.pop_front();
                    if (want.px !== got.px || want.py !== got.py ||
                        want.head !== got.head || want.qz !== got.qz ||
                        want.qw !== got.qw || want.ticks !== got.ticks) begin
                        fail_count++;
                        if (fail_count <= SHOWN_LIMIT) begin
                            $display("%0t pose mismatch", $time);
                            $display("  expected x=%0d y=%0d h=%0d qz=%0d qw=%0d n=%0d",
                                     want.px, want.py, want.head, want.qz, want.qw,
                                     want.ticks);
                            $display("  actual   x=%0d y=%0d h=%0d qz=%0d qw=%0d n=%0d",
                                     got.px, got.py, got.head, got.qz, got.qw,
                                     got.ticks);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                advance_pose(command, vel_forward, vel_lateral, yaw_rate, elapsed_time,
                             want);
                expected_poses.push_back(want);
            end
        end
        pending_count <= expected_poses.size();
    end

endmodule

[bench/planar_odometry_integrator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_top_test: odometry integrator testbench
// drives directed and random tick and fix items through the integrator
// under several idle and stall patterns; a checker beside the block
// predicts each pose and counts mismatches, and this module gives the verdict
// ----------------------------------------------------------------------------
module planar_odometry_integrator_top_test;

    localparam int     CORDIC_STEPS = 16;
    // slowest legal run is far below a millisecond per thousand items
    localparam longint RUN_LIMIT_NS = 20_000_000;
    // long receiver hold-off, in cycles
    localparam int     HOLD_CYCLES  = 500;
    // quiet time after the last result, a bit over one item latency
    localparam int     TAIL_CYCLES  = 2 * CORDIC_STEPS + 40;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [15:0] yaw_rate;
    logic [15:0]        elapsed_time;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [31:0]        tick_number;

    int fail_count;
    int pending_count;

    // percent of cycles the sender idles / the receiver stalls
    int idle_pct;
    int stall_pct;
    // request for the one long receiver hold-off
    logic hold_req;

    planar_odometry_integrator_top #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .vel_forward  (vel_forward),
        .vel_lateral  (vel_lateral),
        .yaw_rate     (yaw_rate),
        .elapsed_time (elapsed_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position_x   (position_x),
        .position_y   (position_y),
        .heading      (heading),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .tick_number  (tick_number)
    );

    odometry_pose_checker #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) pose_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .vel_forward   (vel_forward),
        .vel_lateral   (vel_lateral),
        .yaw_rate      (yaw_rate),
        .elapsed_time  (elapsed_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position_x    (position_x),
        .position_y    (position_y),
        .heading       (heading),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .tick_number   (tick_number),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit, in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // receiver: random stall at the current rate, plus one long hold-off
    // counted here so the sender keeps offering while the block backs up
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // offer one item; returns right after the edge of its transfer
    // idle gaps come first so in_valid gets one assignment per time step
    task automatic send_item(input logic cmd,
                             input logic signed [15:0] vf,
                             input logic signed [15:0] vl,
                             input logic signed [15:0] wr,
                             input logic [15:0] dt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        vel_forward  <= vf;
        vel_lateral  <= vl;
        yaw_rate     <= wr;
        elapsed_time <= dt;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // random tick, now and then a fix; magnitudes often shrunk so that
    // slow everyday motion shows up as well as full-scale values
    task automatic send_random_item();
        logic               cmd;
        logic signed [15:0] vf;
        logic signed [15:0] vl;
        logic signed [15:0] wr;
        logic [15:0]        dt;
        cmd = ($urandom_range(15) == 0);
        vf  = 16'($urandom);
        vl  = 16'($urandom);
        wr  = 16'($urandom);
        dt  = 16'($urandom);
        if ($urandom_range(1) == 0)
            vf = vf >>> $urandom_range(12);
        if ($urandom_range(1) == 0)
            vl = vl >>> $urandom_range(12);
        if ($urandom_range(1) == 0)
            wr = wr >>> $urandom_range(12);
        if ($urandom_range(2) == 0)
            dt = dt >> $urandom_range(10);
        send_item(cmd, vf, vl, wr, dt);
    endtask

    // sender pause: nothing offered until every expected pose is back
    // pending_count is a registered copy, so look only after the next edge
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input int count);
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        repeat (count)
        begin
            send_random_item();
        end
    endtask

    // stimulus
    initial
    begin
        idle_pct     = 0;
        stall_pct    <= 0;
        hold_req     <= 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= 1'b0;
        vel_forward  <= '0;
        vel_lateral  <= '0;
        yaw_rate     <= '0;
        elapsed_time <= '0;
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, exact heading steps (dt of half a second
        // makes the heading step equal the yaw rate), wrap at pi, rounding
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'd0);              // zero time
        send_item(1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
        send_item(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);
        send_item(1'b0, 16'sd256, 16'sd0, 16'sd0, 16'hFFFF);
        send_item(1'b1, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF);        // fix, junk fields
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd12868, 16'd32768);      // just past +pi/2
        send_item(1'b0, 16'sd32767, -16'sd32768, 16'sd0, 16'hFFFF);  // rotate in far half
        send_item(1'b0, 16'sd1000, 16'sd1000, -16'sd25736, 16'd32768); // just past -pi/2
        send_item(1'b0, -16'sd32768, 16'sd32767, 16'sd0, 16'hFFFF);
        send_item(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd25735, 16'd32768);      // top of heading range
        send_item(1'b0, 16'sd32767, 16'sd32767, 16'sd1, 16'd32768);  // wraps to -pi
        send_item(1'b0, -16'sd32768, -16'sd32768, 16'sd0, 16'hFFFF); // quaternion at -pi
        send_item(1'b0, 16'sd0, 16'sd0, -16'sd1, 16'd32768);         // wraps back below -pi
        send_item(1'b0, 16'sd1, -16'sd1, 16'sd1, 16'd1);             // heading step rounds to 0
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd32767, 16'd1);          // rounds up to 1
        send_item(1'b0, 16'sd0, 16'sd0, -16'sd32768, 16'd1);         // exact step of -1
        send_item(1'b1, 16'sd5, 16'sd5, 16'sd5, 16'd5);
        send_item(1'b0, 16'sd32767, 16'sd0, 16'sd0, 16'd0);
        send_item(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);

        // full-speed cruise long enough to wrap the position counters
        send_item(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        repeat (300)
        begin
            send_item(1'b0, 16'sd32767 - 16'($urandom_range(15)),
                      16'($signed(16'($urandom_range(63))) - 16'sd32),
                      16'sd0, 16'hFFFF - 16'($urandom_range(255)));
        end

        run_phase(0, 0, 260);

        // long receiver hold-off while the sender keeps offering
        hold_req <= 1'b1;
        repeat (24)
        begin
            send_random_item();
        end
        wait_drained();

        run_phase(88, 0, 260);
        run_phase(0, 88, 260);
        run_phase(8, 8, 260);
        run_phase(0, 0, 260);

        wait_drained();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
